[design/tile_map_aabb_collision_defines.svh]
// Assertion macros for the tile map collision block.
// Used by the top level only; no other dependencies.
`ifndef TILE_MAP_AABB_COLLISION_DEFINES_SVH
`define TILE_MAP_AABB_COLLISION_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define TMAC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tile map collision check failed");
// Plain invariant, disabled while reset is high.
`define TMAC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tile map collision invariant failed");
`else
`define TMAC_ASSERT_NOW(label, clk, rst, ante, cons)
`define TMAC_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

[design/tmac_pkg.sv]
// Shared constants, types and helper functions for the tile map collision block.
// No dependencies; imported by tmac_div and the top level, but not by tmac_ram.
`timescale 1ns / 1ps
package tmac_pkg;

   // Grid geometry
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int IDX_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int ADDR_W   = COL_W + ROW_W;
   localparam int DEPTH    = MAX_COLS * MAX_ROWS;
   localparam int CODE_W   = 3;
   localparam int CNT_W    = 7;

   // Arithmetic widths
   localparam int SIZE_W  = 31;
   localparam int VAL_W   = 32;
   localparam int DT_W    = 21;
   localparam int PROD_W  = 54;
   localparam int POS_W   = 34;
   localparam int GEO_W   = 41;
   localparam int DIV_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int EPS_Q   = 66;

   // Operation codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_COLLIDE = 2'd2;

   // Tile codes
   localparam logic [CODE_W-1:0] TILE_BLANK = 3'd0;
   localparam logic [CODE_W-1:0] TILE_DIRT  = 3'd1;
   localparam logic [CODE_W-1:0] TILE_ROCK  = 3'd2;

   // Register indexes
   localparam logic [1:0] CSR_BLOCK_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_BLOCK_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GRID_COLUMNS = 2'd2;
   localparam logic [1:0] CSR_GRID_ROWS    = 2'd3;

   // Controller states
   typedef enum logic [15:0] {
      ST_CLEAR     = 16'h0001,
      ST_IDLE      = 16'h0002,
      ST_RD_ISSUE  = 16'h0004,
      ST_RD_DATA   = 16'h0008,
      ST_MULX      = 16'h0010,
      ST_MULY      = 16'h0020,
      ST_MOVY      = 16'h0040,
      ST_PRED      = 16'h0080,
      ST_DIV_START = 16'h0100,
      ST_DIV_WAIT  = 16'h0200,
      ST_SETUP     = 16'h0400,
      ST_BOUND     = 16'h0800,
      ST_ISSUE     = 16'h1000,
      ST_EVAL      = 16'h2000,
      ST_RESOLVE   = 16'h4000,
      ST_DONE      = 16'h8000
   } state_type;

   // Divider status towards the controller
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [GEO_W-1:0] v);
      logic signed [GEO_W-1:0] hi;
      logic signed [GEO_W-1:0] lo;
      hi = GEO_W'(64'sh7FFF_FFFF);
      lo = -GEO_W'(64'sh8000_0000);
      if (v > hi)      sat32 = 32'sh7FFF_FFFF;
      else if (v < lo) sat32 = 32'sh8000_0000;
      else             sat32 = v[VAL_W-1:0];
   endfunction

   // Grid size register as used: zero acts as one, large values as the maximum.
   function automatic logic [CNT_W-1:0] dim_used(input logic [CNT_W-1:0] v,
                                                input int max_v);
      if (v == '0)                 dim_used = CNT_W'(1);
      else if (v > CNT_W'(max_v))  dim_used = CNT_W'(max_v);
      else                         dim_used = v;
   endfunction

endpackage

[design/tmac_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tmac_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tmac_div.sv]
// Restoring divider, one quotient bit per cycle, for tile index lookup.
// Depends on tmac_pkg.
`timescale 1ns / 1ps
module tmac_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tmac_pkg::DIV_W-1:0]   dividend,
   input  logic [tmac_pkg::SIZE_W-1:0]  divisor,
   output logic [tmac_pkg::DIV_W-1:0]   quotient,
   output tmac_pkg::div_status_type     status
);
   import tmac_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W-1:0]     shifted;
   logic [DIV_W-1:0]     divisor_ext;

   assign divisor_ext = DIV_W'(divisor);
   assign shifted     = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};

   // One trial subtraction per cycle.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= divisor_ext) begin
            rem_in = shifted - divisor_ext;
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/tile_map_aabb_collision.sv]
// Top level of the tile map with box collision resolution: controller and datapath.
// Depends on tmac_pkg, tmac_ram, tmac_div and tile_map_aabb_collision_defines.svh.
//
// Usage. Items arrive on the req_ channel (valid/stall) and each gives exactly one
// beat on the rsp_ channel. Tile size and grid size are set through the csr_ write
// port; the user must write them only while the block is idle, and the block itself
// does not enforce this. The tile store is a 4096 x 3 bit RAM.
// After reset the block clears the store, one entry a cycle, holding req_stall
// high; configuration writes are taken throughout.
// The block works on one item at a time. A write goes from ST_IDLE to ST_DONE, a
// read passes ST_RD_ISSUE and ST_RD_DATA (the RAM read is registered), and a
// collision query runs the move and prediction states, four 32-step divisions in
// the shared divider, and one RAM read and one evaluation per tile in the clamped
// scan range. The next item can be taken in the cycle after the result is loaded.
// A new item is accepted as soon as the controller is idle, even while the
// previous result beat still waits; when rsp_stall holds the result register,
// the next item's result waits in the controller until that register frees up.
`timescale 1ns / 1ps
`include "tile_map_aabb_collision_defines.svh"
module tile_map_aabb_collision (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic signed [15:0]                req_map_col,
   input  logic signed [15:0]                req_map_row,
   input  logic [tmac_pkg::CODE_W-1:0]       req_tile_code,
   input  logic signed [tmac_pkg::VAL_W-1:0] req_box_min_x,
   input  logic signed [tmac_pkg::VAL_W-1:0] req_box_min_y,
   input  logic signed [tmac_pkg::VAL_W-1:0] req_box_max_x,
   input  logic signed [tmac_pkg::VAL_W-1:0] req_box_max_y,
   input  logic signed [tmac_pkg::VAL_W-1:0] req_vel_x,
   input  logic signed [tmac_pkg::VAL_W-1:0] req_vel_y,
   input  logic [tmac_pkg::DT_W-1:0]         req_time_step,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tmac_pkg::CODE_W-1:0]       rsp_read_code,
   output logic signed [tmac_pkg::VAL_W-1:0] rsp_move_x,
   output logic signed [tmac_pkg::VAL_W-1:0] rsp_move_y,
   output logic                              rsp_landed,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [tmac_pkg::SIZE_W-1:0]       csr_data
);
   import tmac_pkg::*;

   // Configuration registers
   logic [SIZE_W-1:0] bw_ff, bh_ff;
   logic [CNT_W-1:0]  cols_ff, rows_ff;
   logic [SIZE_W-1:0] bw_used, bh_used;
   logic [CNT_W-1:0]  nc, nr;

   // Controller and work registers
   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [1:0]              op_ff, op_in;
   logic signed [VAL_W-1:0] bminx_ff, bminy_ff, bmaxx_ff, bmaxy_ff;
   logic signed [VAL_W-1:0] bminx_in, bminy_in, bmaxx_in, bmaxy_in;
   logic signed [VAL_W-1:0] vx_ff, vy_ff, vx_in, vy_in;
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic                    ingrid_ff, ingrid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VAL_W-1:0] mx_ff, my_ff, mx_in, my_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic                    landed_ff, landed_in;
   logic signed [POS_W-1:0] pminx_ff, pminy_ff, pmaxx_ff, pmaxy_ff;
   logic signed [POS_W-1:0] pminx_in, pminy_in, pmaxx_in, pmaxy_in;
   logic [1:0]              didx_ff, didx_in;
   logic [IDX_W-1:0]        t_ff [4];
   logic [IDX_W-1:0]        t_in [4];
   logic [IDX_W-1:0]        xb_ff, xe_ff, yb_ff, ye_ff, x_ff, y_ff;
   logic [IDX_W-1:0]        xb_in, xe_in, yb_in, ye_in, x_in, y_in;
   logic signed [GEO_W-1:0] xlo0_ff, xlo_ff, ylo_ff, xlo0_in, xlo_in, ylo_in;
   logic signed [GEO_W-1:0] bestx_ff, besty_ff, bestx_in, besty_in;
   logic                    found_ff, found_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic signed [VAL_W-1:0] rsp_mx_ff, rsp_my_ff, rsp_mx_in, rsp_my_in;
   logic                    rsp_landed_ff, rsp_landed_in;

   // Memory and divider connections
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [CODE_W-1:0]       ram_wdata, ram_rdata;
   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend, div_quotient;
   logic [SIZE_W-1:0]       div_divisor;
   div_status_type          div_st;

   // Combinational helpers
   logic                    req_accept;
   logic                    req_ingrid;
   logic [ADDR_W-1:0]       req_addr;
   logic signed [POS_W-1:0] dsel;
   logic [CNT_W-1:0]        qlim;
   logic [IDX_W-1:0]        qclamp;
   logic [CNT_W-1:0]        scan_row;
   logic signed [GEO_W-1:0] pminx_e, pminy_e, pmaxx_e, pmaxy_e;
   logic signed [GEO_W-1:0] xhi, yhi, ox, oy, lox, hix, loy, hiy;
   logic                    wall, hit;
   logic signed [GEO_W-1:0] push;
   logic signed [GEO_W-1:0] mx_e, my_e;

   assign bw_used = (bw_ff == '0) ? SIZE_W'(1) : bw_ff;
   assign bh_used = (bh_ff == '0) ? SIZE_W'(1) : bh_ff;
   assign nc      = dim_used(cols_ff, MAX_COLS);
   assign nr      = dim_used(rows_ff, MAX_ROWS);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff   <= SIZE_W'(131072);
         bh_ff   <= SIZE_W'(131072);
         cols_ff <= CNT_W'(64);
         rows_ff <= CNT_W'(64);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BLOCK_WIDTH:  bw_ff   <= csr_data;
            CSR_BLOCK_HEIGHT: bh_ff   <= csr_data;
            CSR_GRID_COLUMNS: cols_ff <= csr_data[CNT_W-1:0];
            CSR_GRID_ROWS:    rows_ff <= csr_data[CNT_W-1:0];
            default:          bw_ff   <= bw_ff;
         endcase
      end
   end

   // Input beat decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_ingrid = !req_map_col[15] && !req_map_row[15]
                       && ($unsigned(req_map_col) < 16'(nc))
                       && ($unsigned(req_map_row) < 16'(nr));
   assign req_addr   = {req_map_row[ROW_W-1:0], req_map_col[COL_W-1:0]};

   // Tile store
   tmac_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_we    = (state_ff == ST_CLEAR)
                      || (req_accept && (req_opcode == OP_WRITE) && req_ingrid);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : req_addr;
   assign ram_wdata = (state_ff == ST_CLEAR) ? TILE_BLANK : req_tile_code;
   assign scan_row  = nr - CNT_W'(1) - CNT_W'(y_ff);
   assign ram_raddr = (state_ff == ST_ISSUE)
                      ? {scan_row[ROW_W-1:0], x_ff[COL_W-1:0]} : addr_ff;

   // Shared divider for the four tile index lookups
   tmac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_st)
   );

   // Dividend selection: min edges as they are, max edges less epsilon.
   always_comb begin
      unique case (didx_ff)
         2'd0:    dsel = pminx_ff;
         2'd1:    dsel = pmaxx_ff - POS_W'(EPS_Q);
         2'd2:    dsel = pminy_ff;
         default: dsel = pmaxy_ff - POS_W'(EPS_Q);
      endcase
   end
   assign div_start    = (state_ff == ST_DIV_START);
   assign div_dividend = dsel[POS_W-1] ? '0 : dsel[DIV_W-1:0];
   assign div_divisor  = didx_ff[1] ? bh_used : bw_used;
   assign qlim         = (didx_ff[1] ? nr : nc) - CNT_W'(1);
   assign qclamp       = (div_quotient > DIV_W'(qlim)) ? qlim[IDX_W-1:0]
                                                     : div_quotient[IDX_W-1:0];

   // Overlap of the predicted box with the tile being scanned
   assign pminx_e = GEO_W'(pminx_ff);
   assign pminy_e = GEO_W'(pminy_ff);
   assign pmaxx_e = GEO_W'(pmaxx_ff);
   assign pmaxy_e = GEO_W'(pmaxy_ff);
   assign xhi  = xlo_ff + $signed(GEO_W'(bw_used));
   assign yhi  = ylo_ff + $signed(GEO_W'(bh_used));
   assign hix  = (pmaxx_e < xhi) ? pmaxx_e : xhi;
   assign lox  = (pminx_e > xlo_ff) ? pminx_e : xlo_ff;
   assign hiy  = (pmaxy_e < yhi) ? pmaxy_e : yhi;
   assign loy  = (pminy_e > ylo_ff) ? pminy_e : ylo_ff;
   assign ox   = hix - lox;
   assign oy   = hiy - loy;
   assign wall = (ram_rdata == TILE_DIRT) || (ram_rdata == TILE_ROCK);
   assign hit  = wall && (ox > 0) && (oy > 0);

   assign push = ((bestx_ff < besty_ff) ? bestx_ff : besty_ff) + GEO_W'(EPS_Q);
   assign mx_e = GEO_W'(mx_ff);
   assign my_e = GEO_W'(my_ff);

   // Controller
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      bminx_in  = bminx_ff;
      bminy_in  = bminy_ff;
      bmaxx_in  = bmaxx_ff;
      bmaxy_in  = bmaxy_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      dt_in     = dt_ff;
      addr_in   = addr_ff;
      ingrid_in = ingrid_ff;
      prod_in   = prod_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      code_in   = code_ff;
      landed_in = landed_ff;
      pminx_in  = pminx_ff;
      pminy_in  = pminy_ff;
      pmaxx_in  = pmaxx_ff;
      pmaxy_in  = pmaxy_ff;
      didx_in   = didx_ff;
      t_in      = t_ff;
      xb_in     = xb_ff;
      xe_in     = xe_ff;
      yb_in     = yb_ff;
      ye_in     = ye_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      xlo0_in   = xlo0_ff;
      xlo_in    = xlo_ff;
      ylo_in    = ylo_ff;
      bestx_in  = bestx_ff;
      besty_in  = besty_ff;
      found_in  = found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_mx_in     = rsp_mx_ff;
      rsp_my_in     = rsp_my_ff;
      rsp_landed_in = rsp_landed_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_opcode;
               bminx_in  = req_box_min_x;
               bminy_in  = req_box_min_y;
               bmaxx_in  = req_box_max_x;
               bmaxy_in  = req_box_max_y;
               vx_in     = req_vel_x;
               vy_in     = req_vel_y;
               dt_in     = req_time_step;
               addr_in   = req_addr;
               ingrid_in = req_ingrid;
               mx_in     = '0;
               my_in     = '0;
               code_in   = TILE_BLANK;
               landed_in = 1'b0;
               priority case (req_opcode)
                  OP_READ:    state_in = ST_RD_ISSUE;
                  OP_COLLIDE: state_in = ST_MULX;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            code_in  = ingrid_ff ? ram_rdata : TILE_BLANK;
            state_in = ST_DONE;
         end
         // Move per axis: velocity times time step, floored, then saturated.
         ST_MULX: begin
            prod_in  = $signed({{(PROD_W-VAL_W){vx_ff[VAL_W-1]}}, vx_ff})
                       * $signed(PROD_W'(dt_ff));
            state_in = ST_MULY;
         end
         ST_MULY: begin
            mx_in    = sat32(GEO_W'(prod_ff >>> 16));
            prod_in  = $signed({{(PROD_W-VAL_W){vy_ff[VAL_W-1]}}, vy_ff})
                       * $signed(PROD_W'(dt_ff));
            state_in = ST_MOVY;
         end
         ST_MOVY: begin
            my_in    = sat32(GEO_W'(prod_ff >>> 16));
            state_in = ST_PRED;
         end
         // Predicted box after the move.
         ST_PRED: begin
            pminx_in = POS_W'(bminx_ff) + POS_W'(mx_ff);
            pmaxx_in = POS_W'(bmaxx_ff) + POS_W'(mx_ff);
            pminy_in = POS_W'(bminy_ff) + POS_W'(my_ff);
            pmaxy_in = POS_W'(bmaxy_ff) + POS_W'(my_ff);
            didx_in  = 2'd0;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_st.done) begin
               t_in[didx_ff] = qclamp;
               didx_in       = didx_ff + 2'd1;
               state_in      = (didx_ff == 2'd3) ? ST_SETUP : ST_DIV_START;
            end
         end
         // Scan range in ascending order on each axis.
         ST_SETUP: begin
            xb_in    = (t_ff[0] < t_ff[1]) ? t_ff[0] : t_ff[1];
            xe_in    = (t_ff[0] < t_ff[1]) ? t_ff[1] : t_ff[0];
            yb_in    = (t_ff[2] < t_ff[3]) ? t_ff[2] : t_ff[3];
            ye_in    = (t_ff[2] < t_ff[3]) ? t_ff[3] : t_ff[2];
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            xlo0_in  = $signed(GEO_W'(xb_ff) * GEO_W'(bw_used));
            xlo_in   = $signed(GEO_W'(xb_ff) * GEO_W'(bw_used));
            ylo_in   = $signed(GEO_W'(yb_ff) * GEO_W'(bh_used));
            x_in     = xb_ff;
            y_in     = yb_ff;
            found_in = 1'b0;
            bestx_in = '0;
            besty_in = '0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_EVAL;
         end
         // Keep the least x and least y overlap of wall tiles, then step on.
         ST_EVAL: begin
            if (hit) begin
               if (!found_ff || ox < bestx_ff) bestx_in = ox;
               if (!found_ff || oy < besty_ff) besty_in = oy;
               found_in = 1'b1;
            end
            if (x_ff == xe_ff) begin
               x_in   = xb_ff;
               xlo_in = xlo0_ff;
               y_in   = y_ff + IDX_W'(1);
               ylo_in = yhi;
               state_in = (y_ff == ye_ff) ? ST_RESOLVE : ST_ISSUE;
            end else begin
               x_in     = x_ff + IDX_W'(1);
               xlo_in   = xhi;
               state_in = ST_ISSUE;
            end
         end
         // Push back on the axis with the smaller overlap; ties go to y.
         ST_RESOLVE: begin
            if (found_ff) begin
               if (bestx_ff < besty_ff) begin
                  mx_in = (mx_ff > 0) ? sat32(mx_e - push) : sat32(mx_e + push);
               end else if (my_ff > 0) begin
                  my_in = sat32(my_e - push);
               end else begin
                  my_in     = sat32(my_e + push);
                  landed_in = 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = code_ff;
               rsp_mx_in     = mx_ff;
               rsp_my_in     = my_ff;
               rsp_landed_in = landed_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      bminx_ff  <= bminx_in;
      bminy_ff  <= bminy_in;
      bmaxx_ff  <= bmaxx_in;
      bmaxy_ff  <= bmaxy_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      dt_ff     <= dt_in;
      addr_ff   <= addr_in;
      ingrid_ff <= ingrid_in;
      prod_ff   <= prod_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      code_ff   <= code_in;
      landed_ff <= landed_in;
      pminx_ff  <= pminx_in;
      pminy_ff  <= pminy_in;
      pmaxx_ff  <= pmaxx_in;
      pmaxy_ff  <= pmaxy_in;
      didx_ff   <= didx_in;
      t_ff      <= t_in;
      xb_ff     <= xb_in;
      xe_ff     <= xe_in;
      yb_ff     <= yb_in;
      ye_ff     <= ye_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      xlo0_ff   <= xlo0_in;
      xlo_ff    <= xlo_in;
      ylo_ff    <= ylo_in;
      bestx_ff  <= bestx_in;
      besty_ff  <= besty_in;
      found_ff  <= found_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_mx_ff     <= rsp_mx_in;
      rsp_my_ff     <= rsp_my_in;
      rsp_landed_ff <= rsp_landed_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_code = rsp_code_ff;
   assign rsp_move_x    = rsp_mx_ff;
   assign rsp_move_y    = rsp_my_ff;
   assign rsp_landed    = rsp_landed_ff;

   // Checks
   `TMAC_ASSERT_ALWAYS(a_state_onehot, clock, reset, $onehot(state_ff))
   `TMAC_ASSERT_NOW(a_div_busy_wait, clock, reset, div_st.busy, state_ff == ST_DIV_WAIT)
   `TMAC_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_EVAL,
                    (x_ff <= xe_ff) && (y_ff <= ye_ff) && (op_ff == OP_COLLIDE))
   `TMAC_ASSERT_NOW(a_no_rsp_in_clear, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)

endmodule
